>>> design/window_colour_uniformity_classifier_macros.svh
// Assertion macros shared by the window classifier modules.
`ifndef WINDOW_COLOUR_UNIFORMITY_CLASSIFIER_MACROS_SVH
`define WINDOW_COLOUR_UNIFORMITY_CLASSIFIER_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define WCUC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wcuc assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define WCUC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wcuc assertion failed");

`endif

>>> design/wcuc_pkg.sv
// Package: constants, widths and types of the window classifier.
package wcuc_pkg;

   localparam int GRID_SIZE         = 250;
   localparam int MAX_WINDOW_PIXELS = 256;
   localparam int PERCENT_SCALE     = 100;

   localparam int CHAN_W  = 8;
   localparam int COORD_W = 8;
   localparam int PCT_W   = 7;
   localparam int THR_W   = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam int CHAN_MAX  = (1 << CHAN_W) - 1;
   localparam int COORD_MAX = (1 << COORD_W) - 1;
   localparam int PCT_MAX   = (1 << PCT_W) - 1;

   localparam int CNT_W  = $clog2(MAX_WINDOW_PIXELS + 1);
   localparam int SUM_W  = $clog2(CHAN_MAX * MAX_WINDOW_PIXELS + 1);
   localparam int ROW_SCALED_MAX = COORD_MAX * PERCENT_SCALE;
   localparam int BAND_MAX_MAX   = GRID_SIZE * PCT_MAX;
   localparam int BAND_W = $clog2(((ROW_SCALED_MAX > BAND_MAX_MAX) ?
                                   ROW_SCALED_MAX : BAND_MAX_MAX) + 1);

   localparam int NUM_CHAN = 3;

   localparam logic [CHAN_W-1:0] CLASS_PASS = CHAN_W'(255);
   localparam logic [CHAN_W-1:0] CLASS_FAIL = CHAN_W'(0);

   localparam logic [PCT_W-1:0] CUT_RESET    = PCT_W'(0);
   localparam logic [PCT_W-1:0] DOWN_RESET   = PCT_W'(100);
   localparam logic [THR_W-1:0] SPREAD_RESET = THR_W'(20);
   localparam logic [THR_W-1:0] GREY_RESET   = THR_W'(50);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CUT_PERCENT      = 2'd0,
      CSR_DOWN_PERCENT     = 2'd1,
      CSR_SPREAD_THRESHOLD = 2'd2,
      CSR_GREY_THRESHOLD   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [PCT_W-1:0] cut_percent;
      logic [PCT_W-1:0] down_percent;
      logic [THR_W-1:0] spread_threshold;
      logic [THR_W-1:0] grey_threshold;
   } cfg_type;

   typedef struct packed {
      logic [NUM_CHAN-1:0][CHAN_W-1:0] chan;
      logic [COORD_W-1:0]              row;
      logic [COORD_W-1:0]              col;
      logic                            last;
   } pixel_type;

   typedef struct packed {
      logic [NUM_CHAN-1:0][SUM_W-1:0]  sum;
      logic [NUM_CHAN-1:0][CHAN_W-1:0] max;
      logic [CNT_W-1:0]                count;
      logic                            overflow;
      logic [COORD_W-1:0]              row;
      logic [COORD_W-1:0]              col;
   } snap_type;

   typedef struct packed {
      logic valid;
      logic ready;
   } hs_type;

endpackage

>>> design/wcuc_accum.sv
// Per-window accumulators and end-of-window snapshot register.
`include "window_colour_uniformity_classifier_macros.svh"

module wcuc_accum (
   input  logic                clock,
   input  logic                reset,
   input  logic                pix_valid,
   input  wcuc_pkg::pixel_type pix,
   output logic                pix_ready,
   input  logic                snap_ready,
   output wcuc_pkg::hs_type    snap_hs,
   output wcuc_pkg::snap_type  snap
);

   logic [wcuc_pkg::NUM_CHAN-1:0][wcuc_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [wcuc_pkg::NUM_CHAN-1:0][wcuc_pkg::CHAN_W-1:0] max_ff, max_in;
   logic [wcuc_pkg::CNT_W-1:0] count_ff, count_in;
   logic                       ovf_ff, ovf_in;
   logic                       snap_valid_ff, snap_valid_in;
   wcuc_pkg::snap_type         snap_ff, snap_in;
   logic                       full;
   logic                       pix_take;
   logic                       snap_free;

   assign full      = (count_ff == wcuc_pkg::CNT_W'(wcuc_pkg::MAX_WINDOW_PIXELS));
   assign snap_free = !snap_valid_ff || snap_ready;
   assign pix_ready = !pix.last || snap_free;
   assign pix_take  = pix_valid && pix_ready;

   // running totals including the current pixel, unless the window is already full
   always_comb begin
      sum_in   = sum_ff;
      max_in   = max_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (full) begin
         ovf_in = 1'b1;
      end else begin
         for (int c = 0; c < wcuc_pkg::NUM_CHAN; c++) begin
            sum_in[c] = sum_ff[c] + wcuc_pkg::SUM_W'(pix.chan[c]);
            if (pix.chan[c] > max_ff[c]) begin
               max_in[c] = pix.chan[c];
            end
         end
         count_in = count_ff + wcuc_pkg::CNT_W'(1);
      end
      snap_in.sum      = sum_in;
      snap_in.max      = max_in;
      snap_in.count    = count_in;
      snap_in.overflow = ovf_in;
      snap_in.row      = pix.row;
      snap_in.col      = pix.col;
   end

   always_comb begin
      snap_valid_in = snap_valid_ff;
      if (pix_take && pix.last) begin
         snap_valid_in = 1'b1;
      end else if (snap_ready) begin
         snap_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff        <= '0;
         max_ff        <= '0;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         snap_valid_ff <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
         if (pix_take) begin
            if (pix.last) begin
               sum_ff   <= '0;
               max_ff   <= '0;
               count_ff <= '0;
               ovf_ff   <= 1'b0;
            end else begin
               sum_ff   <= sum_in;
               max_ff   <= max_in;
               count_ff <= count_in;
               ovf_ff   <= ovf_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pix_take && pix.last) begin
         snap_ff <= snap_in;
      end
   end

   assign snap_hs.valid = snap_valid_ff;
   assign snap_hs.ready = snap_ready;
   assign snap          = snap_ff;

   `WCUC_ASSERT_IMPL(a_count_bound, 1'b1,
      count_ff <= wcuc_pkg::CNT_W'(wcuc_pkg::MAX_WINDOW_PIXELS))
   `WCUC_ASSERT_NEXT(a_clear_after_last, pix_take && pix.last,
      count_ff == '0 && !ovf_ff && snap_valid_ff)
   `WCUC_ASSERT_IMPL(a_ovf_only_full, ovf_ff,
      count_ff == wcuc_pkg::CNT_W'(wcuc_pkg::MAX_WINDOW_PIXELS))

endmodule

>>> design/wcuc_classify.sv
// Classification: product stage, compare stage and result register.
`include "window_colour_uniformity_classifier_macros.svh"

module wcuc_classify (
   input  logic                       clock,
   input  logic                       reset,
   input  wcuc_pkg::cfg_type          cfg,
   input  wcuc_pkg::hs_type           snap_hs,
   input  wcuc_pkg::snap_type         snap,
   output logic                       snap_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [wcuc_pkg::COORD_W-1:0] rsp_out_row,
   output logic [wcuc_pkg::COORD_W-1:0] rsp_out_col,
   output logic [wcuc_pkg::CHAN_W-1:0]  rsp_class_value,
   output logic                       rsp_overflow
);

   typedef struct packed {
      logic [wcuc_pkg::NUM_CHAN-1:0][wcuc_pkg::SUM_W-1:0] mxn;
      logic [wcuc_pkg::NUM_CHAN-1:0][wcuc_pkg::SUM_W-1:0] sum;
      logic [wcuc_pkg::SUM_W-1:0]                         spread_n;
      logic [wcuc_pkg::SUM_W-1:0]                         grey_n;
      logic [wcuc_pkg::NUM_CHAN-1:0][wcuc_pkg::SUM_W-1:0] diff;
      logic                                               band_fail;
      logic                                               overflow;
      logic [wcuc_pkg::COORD_W-1:0]                       row;
      logic [wcuc_pkg::COORD_W-1:0]                       col;
   } prod_type;

   prod_type prod_ff, prod_in;
   logic     prod_valid_ff, prod_valid_in;
   logic     rsp_valid_ff;
   logic     out_ready;
   logic     snap_take;
   logic [wcuc_pkg::BAND_W-1:0] row_scaled, band_top, band_bottom;
   logic [wcuc_pkg::SUM_W-1:0]  n_ext;
   logic [wcuc_pkg::CHAN_W-1:0] class_in;
   logic [wcuc_pkg::COORD_W-1:0] row_ff, col_ff;
   logic [wcuc_pkg::CHAN_W-1:0]  class_ff;
   logic                         ovf_ff;
   logic                         not_uniform, not_grey;
   logic [wcuc_pkg::SUM_W-1:0]   excess;

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign snap_ready = !prod_valid_ff || out_ready;
   assign snap_take  = snap_hs.valid && snap_ready;

   function automatic logic [wcuc_pkg::SUM_W-1:0] abs_diff(
      input logic [wcuc_pkg::SUM_W-1:0] a,
      input logic [wcuc_pkg::SUM_W-1:0] b
   );
      return (a >= b) ? a - b : b - a;
   endfunction

   // products and band compares
   always_comb begin
      n_ext       = wcuc_pkg::SUM_W'(snap.count);
      row_scaled  = wcuc_pkg::BAND_W'(snap.row) * wcuc_pkg::BAND_W'(wcuc_pkg::PERCENT_SCALE);
      band_top    = wcuc_pkg::BAND_W'(wcuc_pkg::GRID_SIZE) * wcuc_pkg::BAND_W'(cfg.cut_percent);
      band_bottom = wcuc_pkg::BAND_W'(wcuc_pkg::GRID_SIZE) * wcuc_pkg::BAND_W'(cfg.down_percent);
      for (int c = 0; c < wcuc_pkg::NUM_CHAN; c++) begin
         prod_in.mxn[c] = wcuc_pkg::SUM_W'(snap.max[c]) * n_ext;
      end
      prod_in.sum       = snap.sum;
      prod_in.spread_n  = wcuc_pkg::SUM_W'(cfg.spread_threshold) * n_ext;
      prod_in.grey_n    = wcuc_pkg::SUM_W'(cfg.grey_threshold) * n_ext;
      prod_in.diff[0]   = abs_diff(snap.sum[1], snap.sum[0]);
      prod_in.diff[1]   = abs_diff(snap.sum[1], snap.sum[2]);
      prod_in.diff[2]   = abs_diff(snap.sum[0], snap.sum[2]);
      prod_in.band_fail = (row_scaled < band_top) || (row_scaled > band_bottom);
      prod_in.overflow  = snap.overflow;
      prod_in.row       = snap.row;
      prod_in.col       = snap.col;
   end

   always_comb begin
      prod_valid_in = prod_valid_ff;
      if (snap_take) begin
         prod_valid_in = 1'b1;
      end else if (out_ready) begin
         prod_valid_in = 1'b0;
      end
   end

   // spread and grey compares
   always_comb begin
      not_uniform = 1'b0;
      not_grey    = 1'b0;
      excess      = '0;
      for (int c = 0; c < wcuc_pkg::NUM_CHAN; c++) begin
         excess = (prod_ff.mxn[c] >= prod_ff.sum[c]) ? prod_ff.mxn[c] - prod_ff.sum[c] : '0;
         if (excess >= prod_ff.spread_n) begin
            not_uniform = 1'b1;
         end
         if (prod_ff.diff[c] >= prod_ff.grey_n) begin
            not_grey = 1'b1;
         end
      end
      class_in = (prod_ff.band_fail || not_uniform || not_grey) ?
                 wcuc_pkg::CLASS_FAIL : wcuc_pkg::CLASS_PASS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         if (out_ready) begin
            rsp_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (snap_take) begin
         prod_ff <= prod_in;
      end
      if (out_ready && prod_valid_ff) begin
         row_ff   <= prod_ff.row;
         col_ff   <= prod_ff.col;
         class_ff <= class_in;
         ovf_ff   <= prod_ff.overflow;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_row     = row_ff;
   assign rsp_out_col     = col_ff;
   assign rsp_class_value = class_ff;
   assign rsp_overflow    = ovf_ff;

   `WCUC_ASSERT_IMPL(a_class_code, rsp_valid_ff,
      class_ff == wcuc_pkg::CLASS_FAIL || class_ff == wcuc_pkg::CLASS_PASS)
   `WCUC_ASSERT_NEXT(a_prod_held, prod_valid_ff && !out_ready, prod_valid_ff)
   `WCUC_ASSERT_NEXT(a_prod_loaded, snap_take, prod_valid_ff)

endmodule

>>> design/window_colour_uniformity_classifier.sv
// Top level of the window colour uniformity classifier.
//
//  port group | dir | contents
//  req_*      | in  | item: three channels, window row/col, last-pixel mark
//  rsp_*      | out | item: row, col, class value 0/255, overflow flag
//  csr_*      | in  | write-only registers: cut, down, spread, grey
//
// One pixel accepted per clock while req_stall is low; accumulation keeps up at full rate.
// A window's result passes from the input register through the accumulator
// snapshot, the product stage and the result register.
// Synchronous active-high reset clears accumulators and all valid bits.
// rsp_stall backs up only the classify stages; pixels keep flowing until a
// last pixel finds the snapshot register occupied.
module window_colour_uniformity_classifier (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [wcuc_pkg::CHAN_W-1:0]    req_first_channel,
   input  logic [wcuc_pkg::CHAN_W-1:0]    req_second_channel,
   input  logic [wcuc_pkg::CHAN_W-1:0]    req_third_channel,
   input  logic [wcuc_pkg::COORD_W-1:0]   req_window_row,
   input  logic [wcuc_pkg::COORD_W-1:0]   req_window_col,
   input  logic                           req_last_pixel,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [wcuc_pkg::COORD_W-1:0]   rsp_out_row,
   output logic [wcuc_pkg::COORD_W-1:0]   rsp_out_col,
   output logic [wcuc_pkg::CHAN_W-1:0]    rsp_class_value,
   output logic                           rsp_overflow,
   input  logic                           csr_write,
   input  logic [wcuc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wcuc_pkg::CSR_DATA_W-1:0] csr_data
);

   wcuc_pkg::cfg_type   cfg_ff;
   wcuc_pkg::pixel_type pix_ff;
   logic                pix_valid_ff;
   logic                pix_ready;
   logic                req_take;
   logic                snap_ready;
   wcuc_pkg::hs_type    snap_hs;
   wcuc_pkg::snap_type  snap;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cut_percent      <= wcuc_pkg::CUT_RESET;
         cfg_ff.down_percent     <= wcuc_pkg::DOWN_RESET;
         cfg_ff.spread_threshold <= wcuc_pkg::SPREAD_RESET;
         cfg_ff.grey_threshold   <= wcuc_pkg::GREY_RESET;
      end else if (csr_write) begin
         case (wcuc_pkg::csr_index_type'(csr_index))
            wcuc_pkg::CSR_CUT_PERCENT: begin
               cfg_ff.cut_percent <= csr_data[wcuc_pkg::PCT_W-1:0];
            end
            wcuc_pkg::CSR_DOWN_PERCENT: begin
               cfg_ff.down_percent <= csr_data[wcuc_pkg::PCT_W-1:0];
            end
            wcuc_pkg::CSR_SPREAD_THRESHOLD: begin
               cfg_ff.spread_threshold <= csr_data[wcuc_pkg::THR_W-1:0];
            end
            wcuc_pkg::CSR_GREY_THRESHOLD: begin
               cfg_ff.grey_threshold <= csr_data[wcuc_pkg::THR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign req_stall = pix_valid_ff && !pix_ready;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
      end else if (req_take) begin
         pix_valid_ff <= 1'b1;
      end else if (pix_ready) begin
         pix_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         pix_ff.chan[0] <= req_first_channel;
         pix_ff.chan[1] <= req_second_channel;
         pix_ff.chan[2] <= req_third_channel;
         pix_ff.row     <= req_window_row;
         pix_ff.col     <= req_window_col;
         pix_ff.last    <= req_last_pixel;
      end
   end

   wcuc_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .pix_valid  (pix_valid_ff),
      .pix        (pix_ff),
      .pix_ready  (pix_ready),
      .snap_ready (snap_ready),
      .snap_hs    (snap_hs),
      .snap       (snap)
   );

   wcuc_classify u_classify (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .snap_hs         (snap_hs),
      .snap            (snap),
      .snap_ready      (snap_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_class_value (rsp_class_value),
      .rsp_overflow    (rsp_overflow)
   );

endmodule
